// ===== rtl/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// Range coder encoder package
// Widths, constants and the control structs shared by the encoder modules.
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int PROB_BITS   = 12;
  localparam int WORK_BITS   = 32;
  localparam int SYM_LOW_W   = PROB_BITS;
  localparam int SYM_WIDTH_W = PROB_BITS + 1;
  localparam int SCALE_W     = WORK_BITS - (PROB_BITS - 1);
  localparam int PROD_W      = SCALE_W + SYM_WIDTH_W;
  localparam int BYTE_W      = 8;

  localparam logic [WORK_BITS-1:0] WIDTH_FULL   = WORK_BITS'(1) << (WORK_BITS - 1);
  localparam logic [WORK_BITS-1:0] RENORM_LIMIT = WORK_BITS'(1) << (WORK_BITS - 9);
  localparam logic [1:0]           RENORM_MAX   = 2'd3;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic EV_BYTE  = 1'b0;
  localparam logic EV_CARRY = 1'b1;

  typedef struct packed {
    logic              push;
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              fin;
  } rce_ctl_t;

  typedef struct packed {
    logic push_ready;
    logic fin_done;
  } rce_sts_t;

endpackage

// ===== rtl/rce_item_if.sv =====
// ----------------------------------------------------------------------------
// Range coder item channel
// Valid/ready channel that carries one encode or flush request.
// ----------------------------------------------------------------------------
interface rce_item_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [rce_pkg::SYM_LOW_W-1:0]     sym_low;
  logic [rce_pkg::SYM_WIDTH_W-1:0]   sym_width;

  modport source (output valid, output cmd, output sym_low, output sym_width, input ready);
  modport sink   (input valid, input cmd, input sym_low, input sym_width, output ready);
endinterface

// ===== rtl/rce_result_if.sv =====
// ----------------------------------------------------------------------------
// Range coder result channel
// Valid/ready channel that carries one output byte or carry event.
// ----------------------------------------------------------------------------
interface rce_result_if;
  logic                         valid;
  logic                         ready;
  logic                         event_kind;
  logic [rce_pkg::BYTE_W-1:0]   out_byte;
  logic                         last;

  modport source (output valid, output event_kind, output out_byte, output last, input ready);
  modport sink   (input valid, input event_kind, input out_byte, input last, output ready);
endinterface

// ===== rtl/rce_mul.sv =====
// ----------------------------------------------------------------------------
// Range coder shared multiplier
// Registered scale-by-frequency product used for both interval updates.
// ----------------------------------------------------------------------------
module rce_mul (
  input  logic                             clk,
  input  logic [rce_pkg::SCALE_W-1:0]      a,
  input  logic [rce_pkg::SYM_WIDTH_W-1:0]  b,
  output logic [rce_pkg::PROD_W-1:0]       prod
);

  always_ff @(posedge clk) begin
    prod <= rce_pkg::PROD_W'(a) * rce_pkg::PROD_W'(b);
  end

endmodule

// ===== rtl/rce_out_stage.sv =====
// ----------------------------------------------------------------------------
// Range coder output stage
// Holds one event back until the next one or the end of the request is known,
// so that the last flag can be set, then presents it in an output register.
// ----------------------------------------------------------------------------
module rce_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  rce_pkg::rce_ctl_t    ctl,
  output rce_pkg::rce_sts_t    sts,
  rce_result_if.source         result
);

  logic                       pend_valid;
  logic                       pend_kind;
  logic [rce_pkg::BYTE_W-1:0] pend_byte;
  logic                       out_valid;
  logic                       out_kind;
  logic [rce_pkg::BYTE_W-1:0] out_data;
  logic                       out_last;
  logic                       out_free;

  assign out_free       = !out_valid || result.ready;
  assign sts.push_ready = !pend_valid || out_free;
  assign sts.fin_done   = !pend_valid || out_free;

  assign result.valid      = out_valid;
  assign result.event_kind = out_kind;
  assign result.out_byte   = out_data;
  assign result.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.push && sts.push_ready) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_kind  <= pend_kind;
          out_data  <= pend_byte;
          out_last  <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_kind  <= ctl.kind;
        pend_byte  <= ctl.data;
      end else if (ctl.fin && pend_valid && out_free) begin
        out_valid  <= 1'b1;
        out_kind   <= pend_kind;
        out_data   <= pend_byte;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  a_fin_drains: assert property (@(posedge clk) disable iff (rst)
    (ctl.fin && sts.fin_done) |=> !pend_valid)
    else $error("held event survived the end of a request");

  a_push_forwards: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && pend_valid && out_free) |=> (out_valid && !out_last && pend_valid))
    else $error("held event was not forwarded on a new event");

  a_fin_marks_last: assert property (@(posedge clk) disable iff (rst)
    (ctl.fin && !ctl.push && pend_valid && out_free) |=> (out_valid && out_last))
    else $error("final event not marked last");

endmodule

// ===== rtl/range_coder_encoder.sv =====
// ----------------------------------------------------------------------------
// Range coder encoder
// Byte-oriented range encoder with a 32-bit low and width and carry events.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel: cmd 0 narrows the interval to the
// symbol range given by sym_low and sym_width, cmd 1 flushes the stream and
// returns the coder to its initial state. Each request yields zero to five
// events on the result channel, either a code byte or a carry into bytes
// already sent; last is set on the final event of a request.
// One request is worked at a time and item.ready is high only when idle.
// A sequencer steps a single registered multiplier and one 33-bit adder:
// an encode steps through RENORM_A, MUL_LOW, MUL_WID, SET_WID, CARRY and
// FINISH, a flush through RENORM_A, FLUSH_ADD, CARRY, RENORM_B, TAIL and
// FINISH, and the next request is taken once the sequencer is back in IDLE.
// An event reaches the result channel through a hold register and then the
// output register, since it is held until the next event or the end of the
// request settles its last flag.
// When the receiver stalls, the sequencer waits on each new event and the
// request takes correspondingly longer; nothing is dropped.
// Reset sets the width to 2^31 and low to zero and empties the output stage.
// ----------------------------------------------------------------------------
module range_coder_encoder (
  input  logic          clk,
  input  logic          rst,
  rce_item_if.sink      item,
  rce_result_if.source  result
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RENORM_A,
    ST_MUL_LOW,
    ST_MUL_WID,
    ST_SET_WID,
    ST_FLUSH_ADD,
    ST_CARRY,
    ST_RENORM_B,
    ST_TAIL,
    ST_FINISH
  } state_t;

  state_t                              state;
  logic [rce_pkg::WORK_BITS-1:0]       range_width;
  logic [rce_pkg::WORK_BITS-1:0]       range_low;
  logic                                cmd;
  logic [rce_pkg::SYM_LOW_W-1:0]       sym_low;
  logic [rce_pkg::SYM_WIDTH_W-1:0]     sym_width;
  logic [1:0]                          cnt;
  logic                                carry;

  logic [rce_pkg::SCALE_W-1:0]         mul_a;
  logic [rce_pkg::SYM_WIDTH_W-1:0]     mul_b;
  logic [rce_pkg::PROD_W-1:0]          prod;
  logic [rce_pkg::WORK_BITS-1:0]       addend;
  logic [rce_pkg::WORK_BITS:0]         sum;
  logic [rce_pkg::WORK_BITS-1:0]       width_next;
  logic [rce_pkg::WORK_BITS-1:0]       half_width;
  logic                                renorm_state;
  logic                                shift_go;
  logic                                tail_go;

  rce_pkg::rce_ctl_t                   ctl;
  rce_pkg::rce_sts_t                   sts;

  rce_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rce_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sts    (sts),
    .result (result)
  );

  assign item.ready = (state == ST_IDLE);

  assign mul_a = range_width[rce_pkg::WORK_BITS-1 -: rce_pkg::SCALE_W];
  assign mul_b = (state == ST_MUL_LOW) ? rce_pkg::SYM_WIDTH_W'(sym_low) : sym_width;

  assign addend = (state == ST_FLUSH_ADD) ? range_width : prod[rce_pkg::WORK_BITS-1:0];
  assign sum    = {1'b0, range_low} + {1'b0, addend};

  always_comb begin
    if (|prod[rce_pkg::PROD_W-1:rce_pkg::WORK_BITS+1]) begin
      width_next = '1;
    end else if (prod[rce_pkg::WORK_BITS:1] == '0) begin
      width_next = rce_pkg::WORK_BITS'(1);
    end else begin
      width_next = prod[rce_pkg::WORK_BITS:1];
    end
  end

  assign half_width = (range_width[rce_pkg::WORK_BITS-1:1] == '0) ?
                      rce_pkg::WORK_BITS'(1) : (range_width >> 1);

  assign renorm_state = (state == ST_RENORM_A) || (state == ST_RENORM_B);
  assign shift_go     = renorm_state && (cnt != rce_pkg::RENORM_MAX) &&
                        (range_width <= rce_pkg::RENORM_LIMIT);
  assign tail_go      = (state == ST_TAIL) &&
                        (!range_width[rce_pkg::WORK_BITS-1] ? sts.push_ready : 1'b1);

  always_comb begin
    ctl      = '0;
    ctl.kind = rce_pkg::EV_BYTE;
    ctl.data = range_low[rce_pkg::WORK_BITS-1 -: rce_pkg::BYTE_W];
    case (state)
      ST_RENORM_A, ST_RENORM_B: begin
        ctl.push = shift_go;
      end
      ST_CARRY: begin
        ctl.push = carry;
        ctl.kind = rce_pkg::EV_CARRY;
        ctl.data = '0;
      end
      ST_TAIL: begin
        ctl.push = !range_width[rce_pkg::WORK_BITS-1];
      end
      ST_FINISH: begin
        ctl.fin = 1'b1;
      end
      default: begin
        ctl.push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      range_width <= rce_pkg::WIDTH_FULL;
      range_low   <= '0;
      cnt         <= '0;
      carry       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            cmd       <= item.cmd;
            sym_low   <= item.sym_low;
            sym_width <= item.sym_width;
            cnt       <= '0;
            state     <= ST_RENORM_A;
          end
        end
        ST_RENORM_A, ST_RENORM_B: begin
          if (shift_go) begin
            if (sts.push_ready) begin
              range_low   <= range_low << rce_pkg::BYTE_W;
              range_width <= range_width << rce_pkg::BYTE_W;
              cnt         <= cnt + 2'd1;
            end
          end else begin
            cnt <= '0;
            if (state == ST_RENORM_B) begin
              state <= ST_TAIL;
            end else if (cmd == rce_pkg::CMD_FLUSH) begin
              state <= ST_FLUSH_ADD;
            end else begin
              state <= ST_MUL_LOW;
            end
          end
        end
        ST_MUL_LOW: begin
          state <= ST_MUL_WID;
        end
        ST_MUL_WID: begin
          range_low <= sum[rce_pkg::WORK_BITS-1:0];
          carry     <= sum[rce_pkg::WORK_BITS];
          state     <= ST_SET_WID;
        end
        ST_SET_WID: begin
          range_width <= width_next;
          state       <= ST_CARRY;
        end
        ST_FLUSH_ADD: begin
          range_low   <= sum[rce_pkg::WORK_BITS-1:0];
          carry       <= sum[rce_pkg::WORK_BITS];
          range_width <= half_width;
          state       <= ST_CARRY;
        end
        ST_CARRY: begin
          if (!carry || sts.push_ready) begin
            carry <= 1'b0;
            state <= (cmd == rce_pkg::CMD_FLUSH) ? ST_RENORM_B : ST_FINISH;
          end
        end
        ST_TAIL: begin
          if (tail_go) begin
            range_width <= rce_pkg::WIDTH_FULL;
            range_low   <= '0;
            state       <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (sts.fin_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SET_WID) |=> (range_width != '0))
    else $error("interval width collapsed to zero");

  a_flush_restarts: assert property (@(posedge clk) disable iff (rst)
    tail_go |=> (range_width == rce_pkg::WIDTH_FULL && range_low == '0))
    else $error("flush did not restore the initial interval");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state == ST_RENORM_A && !item.ready))
    else $error("accepted request did not start the sequencer");

endmodule

// ===== sim/range_coder_encoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range coder encoder checker
// Watches the request and result channels, keeps its own copy of the coder's
// low and width, predicts the byte and carry events of every accepted request
// and compares each accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module range_coder_encoder_checker (
  input  logic   clk,
  input  logic   rst,
  rce_item_if    item,
  rce_result_if  result,
  output int     error_count,
  output int     pending_count
);

  typedef struct packed {
    logic                       kind;
    logic [rce_pkg::BYTE_W-1:0] data;
    logic                       last;
  } coded_event_t;

  coded_event_t                  expected_events[$];
  logic [rce_pkg::WORK_BITS-1:0] coder_width;
  logic [rce_pkg::WORK_BITS-1:0] coder_low;
  int                            fails;

  task automatic push_event(input logic kind, input logic [rce_pkg::BYTE_W-1:0] data);
    coded_event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.last = 1'b0;
    expected_events.push_back(ev);
  endtask

  task automatic shift_out_bytes();
    for (int i = 0; i < 3 && coder_width <= rce_pkg::RENORM_LIMIT; i++) begin
      push_event(rce_pkg::EV_BYTE, coder_low[31:24]);
      coder_low   = coder_low << 8;
      coder_width = coder_width << 8;
    end
  endtask

  task automatic predict_coding(input logic cmd,
                                input logic [rce_pkg::SYM_LOW_W-1:0] sym_low,
                                input logic [rce_pkg::SYM_WIDTH_W-1:0] sym_width);
    int                            first;
    logic [rce_pkg::WORK_BITS-1:0] scale;
    logic [rce_pkg::WORK_BITS-1:0] prev_low;
    logic [63:0]                   new_width;
    coded_event_t                  ev;
    first = expected_events.size();
    shift_out_bytes();
    if (cmd == rce_pkg::CMD_ENCODE) begin
      scale     = coder_width >> (rce_pkg::PROB_BITS - 1);
      prev_low  = coder_low;
      coder_low = prev_low + scale * sym_low;
      new_width = (64'(scale) * 64'(sym_width)) >> 1;
      if (new_width > 64'hFFFF_FFFF) new_width = 64'hFFFF_FFFF;
      if (new_width == 64'd0) new_width = 64'd1;
      coder_width = new_width[31:0];
      if (prev_low > coder_low) push_event(rce_pkg::EV_CARRY, '0);
    end else begin
      prev_low    = coder_low;
      coder_low   = prev_low + coder_width;
      coder_width = coder_width >> 1;
      if (coder_width == '0) coder_width = rce_pkg::WORK_BITS'(1);
      if (prev_low > coder_low) push_event(rce_pkg::EV_CARRY, '0);
      shift_out_bytes();
      if (coder_width < rce_pkg::WIDTH_FULL) push_event(rce_pkg::EV_BYTE, coder_low[31:24]);
      coder_width = rce_pkg::WIDTH_FULL;
      coder_low   = '0;
    end
    if (expected_events.size() > first) begin
      ev = expected_events[expected_events.size() - 1];
      ev.last = 1'b1;
      expected_events[expected_events.size() - 1] = ev;
    end
  endtask

  always @(posedge clk) begin
    coded_event_t want;
    if (rst) begin
      expected_events.delete();
      coder_width = rce_pkg::WIDTH_FULL;
      coder_low   = '0;
    end else begin
      if (item.valid && item.ready) begin
        predict_coding(item.cmd, item.sym_low, item.sym_width);
      end
      if (result.valid && result.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_kind %0d out_byte 0x%02h last %0d",
                 result.event_kind, result.out_byte, result.last);
          fails++;
        end else begin
          want = expected_events.pop_front();
          if (result.event_kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, result.event_kind);
            fails++;
          end
          if (result.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, result.out_byte);
            fails++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            fails++;
          end
        end
      end
    end
    error_count   <= fails;
    pending_count <= expected_events.size();
  end

endmodule

// ===== sim/range_coder_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range coder encoder testbench
// Sends directed and random encode and flush requests under changing amounts
// of sender idling and receiver back-pressure, including one long receiver
// hold-off, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module range_coder_encoder_tb;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   send_idle  = 0;
  int   recv_stall = 0;
  int   hold_left  = 0;
  logic hold_req   = 1'b0;

  rce_item_if   item_ch ();
  rce_result_if result_ch ();

  range_coder_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  range_coder_encoder_checker chk (
    .clk           (clk),
    .rst           (rst),
    .item          (item_ch),
    .result        (result_ch),
    .error_count   (fail_count),
    .pending_count (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_request(input logic cmd,
                              input logic [rce_pkg::SYM_LOW_W-1:0] sym_low,
                              input logic [rce_pkg::SYM_WIDTH_W-1:0] sym_width);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.cmd       <= cmd;
    item_ch.sym_low   <= sym_low;
    item_ch.sym_width <= sym_width;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic send_symbol();
    logic [rce_pkg::SYM_LOW_W-1:0]   sym_low;
    logic [rce_pkg::SYM_WIDTH_W-1:0] sym_width;
    case ($urandom_range(19))
      0: begin
        sym_low   = rce_pkg::SYM_LOW_W'($urandom);
        sym_width = rce_pkg::SYM_WIDTH_W'($urandom);
      end
      1: begin
        sym_low   = rce_pkg::SYM_LOW_W'($urandom);
        sym_width = $urandom_range(1) ? 13'd0 : 13'd4096;
      end
      2: begin
        sym_width = rce_pkg::SYM_WIDTH_W'($urandom_range(1, 4096));
        sym_low   = rce_pkg::SYM_LOW_W'(4096 - int'(sym_width));
      end
      default: begin
        sym_width = rce_pkg::SYM_WIDTH_W'($urandom_range(1, 4096));
        sym_low   = rce_pkg::SYM_LOW_W'($urandom_range(0, 4096 - int'(sym_width)));
      end
    endcase
    send_request(rce_pkg::CMD_ENCODE, sym_low, sym_width);
  endtask

  task automatic send_streams(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 16);
      if (len > count - sent) len = count - sent;
      for (int i = 0; i < len; i++) begin
        send_symbol();
        sent++;
      end
      if ($urandom_range(9) != 0) begin
        send_request(rce_pkg::CMD_FLUSH, rce_pkg::SYM_LOW_W'($urandom),
                     rce_pkg::SYM_WIDTH_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.cmd       <= rce_pkg::CMD_ENCODE;
    item_ch.sym_low   <= '0;
    item_ch.sym_width <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle  = 19;
    recv_stall = 19;
    send_request(rce_pkg::CMD_ENCODE, 12'd0, 13'd4096);
    send_request(rce_pkg::CMD_ENCODE, 12'd4095, 13'd1);
    send_request(rce_pkg::CMD_ENCODE, 12'd4095, 13'd1);
    send_request(rce_pkg::CMD_ENCODE, 12'd2048, 13'd0);
    send_request(rce_pkg::CMD_ENCODE, 12'd4095, 13'd0);
    send_request(rce_pkg::CMD_ENCODE, 12'd0, 13'd1);
    send_request(rce_pkg::CMD_FLUSH, 12'd4095, 13'd8191);
    send_request(rce_pkg::CMD_FLUSH, 12'd0, 13'd0);
    send_request(rce_pkg::CMD_ENCODE, 12'd0, 13'd8191);
    send_request(rce_pkg::CMD_ENCODE, 12'd4095, 13'd8191);
    send_request(rce_pkg::CMD_ENCODE, 12'd4095, 13'd8191);
    send_request(rce_pkg::CMD_FLUSH, 12'd1234, 13'd4096);
    send_request(rce_pkg::CMD_ENCODE, 12'd1, 13'd2);
    send_request(rce_pkg::CMD_ENCODE, 12'd4094, 13'd4096);
    send_request(rce_pkg::CMD_ENCODE, 12'd3000, 13'd100);
    send_request(rce_pkg::CMD_FLUSH, 12'd0, 13'd1);
    send_request(rce_pkg::CMD_ENCODE, 12'd0, 13'd0);
    send_request(rce_pkg::CMD_ENCODE, 12'd0, 13'd0);
    send_request(rce_pkg::CMD_ENCODE, 12'd0, 13'd0);
    send_request(rce_pkg::CMD_FLUSH, 12'd2730, 13'd5461);

    send_idle  = 0;
    recv_stall = 0;
    send_streams(40);
    send_idle  = 62;
    send_streams(35);
    send_idle  = 0;
    recv_stall = 62;
    send_streams(35);
    send_idle  = 19;
    recv_stall = 19;
    send_streams(40);
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b1;
    send_streams(40);

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
